// ===== design/urs_pkg.sv =====
// shared types and constants of the ultrasonic ranging sequencer
package urs_pkg;

    localparam int NUM_CHANNELS = 3;

    typedef enum logic [5:0] {
        PH_IDLE      = 6'b000001,
        PH_WAIT_LOW  = 6'b000010,
        PH_SETTLE    = 6'b000100,
        PH_TRIG_HIGH = 6'b001000,
        PH_WAIT_RISE = 6'b010000,
        PH_WAIT_FALL = 6'b100000
    } phase_t;

    localparam logic [2:0] ST_OK            = 3'd0;
    localparam logic [2:0] ST_ECHO_NOT_LOW  = 3'd1;
    localparam logic [2:0] ST_RISE_TIMEOUT  = 3'd2;
    localparam logic [2:0] ST_FALL_TIMEOUT  = 3'd3;
    localparam logic [2:0] ST_OUT_OF_BOUNDS = 3'd4;
    localparam logic [2:0] ST_NOT_READY     = 3'd5;

    localparam logic [1:0] REG_ECHO_TIMEOUT = 2'd0;
    localparam logic [1:0] REG_SETTLE       = 2'd1;
    localparam logic [1:0] REG_PULSE        = 2'd2;
    localparam logic [1:0] REG_GAP          = 2'd3;

    localparam logic [19:0] ECHO_TIMEOUT_RST = 20'd30000;
    localparam logic [15:0] SETTLE_RST       = 16'd2;
    localparam logic [15:0] PULSE_RST        = 16'd10;
    localparam logic [19:0] GAP_RST          = 20'd60000;

    // distance = (width * 343 + 1000) / 2000, done as ((x >> 4) * RECIP_125) >> 32
    localparam logic [28:0] MM_ROUND  = 29'd1000;
    localparam logic [25:0] RECIP_125 = 26'd34359739;
    localparam logic [15:0] MM_MAX    = 16'hffff;

    typedef struct packed {
        logic [2:0]  trigger_lines;
        logic        done;
        logic [1:0]  channel;
        logic [2:0]  status;
        logic [19:0] width;
        logic [31:0] time_ms;
    } tick_res_t;

endpackage

// ===== design/urs_if.sv =====
// tick and result channel interfaces
interface urs_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] time_us;
    logic [31:0] time_ms;
    logic [2:0]  echo_levels;

    modport source (output valid, output time_us, output time_ms, output echo_levels,
                    input ready);
    modport sink (input valid, input time_us, input time_ms, input echo_levels,
                  output ready);
endinterface

interface urs_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  trigger_lines;
    logic        measurement_done;
    logic [1:0]  done_channel;
    logic [2:0]  done_status;
    logic [15:0] range_mm;
    logic [19:0] echo_width_us;
    logic [31:0] update_time_ms;

    modport source (output valid, output trigger_lines, output measurement_done,
                    output done_channel, output done_status, output range_mm,
                    output echo_width_us, output update_time_ms, input ready);
    modport sink (input valid, input trigger_lines, input measurement_done,
                  input done_channel, input done_status, input range_mm,
                  input echo_width_us, input update_time_ms, output ready);
endinterface

// ===== design/ultrasonic_ranging_sequencer_unit.sv =====
// ultrasonic ranging sequencer: round-robin echo timing and distance conversion
//
// in_ch carries one service tick per transfer: microsecond time, millisecond
// time and the echo level of every sensor. out_ch returns exactly one result
// per tick: trigger levels after the tick and, when a channel finished, its
// status, distance, echo width and millisecond stamp.
// the sequencing state updates at the tick transfer itself; the result then
// moves through three registered stages (state decision, width scaling,
// reciprocal multiply with saturation) and is offered from the last of them.
// one tick is taken every cycle while out_ch keeps up.
// when out_ch stalls, each stage holds and in_ch takes ticks until all three
// stages are full, then drops ready until the receiver moves again.
// the apb port writes the four timing registers at byte offsets 0, 4, 8, 12
// and reads them back; write them only while no ticks are in flight.
// reset clears all stages, stops any measurement, sets every register to its
// default and schedules the first channel for time zero.
module ultrasonic_ranging_sequencer_unit (
    input  logic        clk,
    input  logic        rst_n,
    urs_in_if.sink      in_ch,
    urs_out_if.source   out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IDX_W = (urs_pkg::NUM_CHANNELS > 1) ? $clog2(urs_pkg::NUM_CHANNELS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(urs_pkg::NUM_CHANNELS - 1);

    logic [19:0] timeout_reg;
    logic [15:0] settle_reg;
    logic [15:0] pulse_reg;
    logic [19:0] gap_reg;

    logic              measuring_reg, measuring_next;
    logic [IDX_W-1:0]  active_reg, active_next;
    logic [IDX_W-1:0]  next_idx_reg, next_idx_next;
    logic [31:0]       next_start_reg, next_start_next;
    urs_pkg::phase_t   phase_reg, phase_next;
    logic [31:0]       phase_start_reg, phase_start_next;

    logic                 a_valid_reg;
    urs_pkg::tick_res_t   a_res_reg;
    urs_pkg::tick_res_t   a_res_next;
    logic                 b_valid_reg;
    urs_pkg::tick_res_t   b_res_reg;
    logic [24:0]          b_scaled_reg;
    logic                 out_valid_reg;
    urs_pkg::tick_res_t   out_res_reg;
    logic [15:0]          out_dist_reg;

    logic        a_ready, b_ready, c_ready;
    logic        accept;
    logic        cfg_write;
    logic [31:0] now_us;
    logic [31:0] dur;
    logic [31:0] start_diff;
    logic [31:0] timeout_ext;
    logic [7:0]  echo_ext;
    logic [2:0]  ch_ext;
    logic [2:0]  start_ext;
    logic        echo;
    logic        start_echo;
    logic        width_ok;
    logic        fin;
    logic [2:0]  fin_status;
    logic [28:0] width_x;
    logic [28:0] scaled_x;
    logic [50:0] product;
    logic [18:0] quotient;
    logic [15:0] sat_mm;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= urs_pkg::ECHO_TIMEOUT_RST;
            settle_reg  <= urs_pkg::SETTLE_RST;
            pulse_reg   <= urs_pkg::PULSE_RST;
            gap_reg     <= urs_pkg::GAP_RST;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                urs_pkg::REG_ECHO_TIMEOUT: timeout_reg <= pwdata[19:0];
                urs_pkg::REG_SETTLE:       settle_reg  <= pwdata[15:0];
                urs_pkg::REG_PULSE:        pulse_reg   <= pwdata[15:0];
                urs_pkg::REG_GAP:          gap_reg     <= pwdata[19:0];
                default:                   timeout_reg <= timeout_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            urs_pkg::REG_ECHO_TIMEOUT: prdata = {12'd0, timeout_reg};
            urs_pkg::REG_SETTLE:       prdata = {16'd0, settle_reg};
            urs_pkg::REG_PULSE:        prdata = {16'd0, pulse_reg};
            urs_pkg::REG_GAP:          prdata = {12'd0, gap_reg};
            default:                   prdata = 32'd0;
        endcase
    end

    // handshake chain
    assign c_ready     = !out_valid_reg || out_ch.ready;
    assign b_ready     = !b_valid_reg || c_ready;
    assign a_ready     = !a_valid_reg || b_ready;
    assign in_ch.ready = a_ready;
    assign accept      = in_ch.valid && a_ready;

    // sequencing decision for one tick
    assign now_us      = in_ch.time_us;
    assign dur         = now_us - phase_start_reg;
    assign start_diff  = now_us - next_start_reg;
    assign timeout_ext = {12'd0, timeout_reg};
    assign echo_ext    = {5'd0, in_ch.echo_levels};
    assign ch_ext      = 3'(active_reg);
    assign start_ext   = 3'(next_idx_reg);
    assign echo        = echo_ext[ch_ext];
    assign start_echo  = echo_ext[start_ext];
    assign width_ok    = (dur != 32'd0) && (dur < timeout_ext);

    always_comb
    begin
        measuring_next   = measuring_reg;
        active_next      = active_reg;
        next_idx_next    = next_idx_reg;
        next_start_next  = next_start_reg;
        phase_next       = phase_reg;
        phase_start_next = phase_start_reg;
        fin              = 1'b0;
        fin_status       = urs_pkg::ST_OK;
        a_res_next       = '0;

        if (!measuring_reg)
        begin
            if (!start_diff[31])
            begin
                measuring_next   = 1'b1;
                active_next      = next_idx_reg;
                phase_start_next = now_us;
                phase_next       = start_echo ? urs_pkg::PH_WAIT_LOW : urs_pkg::PH_SETTLE;
            end
        end
        else
        begin
            case (phase_reg)
                urs_pkg::PH_WAIT_LOW:
                begin
                    if (!echo)
                    begin
                        phase_next       = urs_pkg::PH_SETTLE;
                        phase_start_next = now_us;
                    end
                    else if (dur >= timeout_ext)
                    begin
                        fin        = 1'b1;
                        fin_status = urs_pkg::ST_ECHO_NOT_LOW;
                    end
                end
                urs_pkg::PH_SETTLE:
                begin
                    if (dur >= {16'd0, settle_reg})
                    begin
                        phase_next       = urs_pkg::PH_TRIG_HIGH;
                        phase_start_next = now_us;
                    end
                end
                urs_pkg::PH_TRIG_HIGH:
                begin
                    if (dur >= {16'd0, pulse_reg})
                    begin
                        phase_next       = urs_pkg::PH_WAIT_RISE;
                        phase_start_next = now_us;
                    end
                end
                urs_pkg::PH_WAIT_RISE:
                begin
                    if (echo)
                    begin
                        phase_next       = urs_pkg::PH_WAIT_FALL;
                        phase_start_next = now_us;
                    end
                    else if (dur >= timeout_ext)
                    begin
                        fin        = 1'b1;
                        fin_status = urs_pkg::ST_RISE_TIMEOUT;
                    end
                end
                urs_pkg::PH_WAIT_FALL:
                begin
                    // rise time equals the phase start, so the width is dur
                    if (!echo)
                    begin
                        fin        = 1'b1;
                        fin_status = width_ok ? urs_pkg::ST_OK : urs_pkg::ST_OUT_OF_BOUNDS;
                    end
                    else if (dur >= timeout_ext)
                    begin
                        fin        = 1'b1;
                        fin_status = urs_pkg::ST_FALL_TIMEOUT;
                    end
                end
                default:
                begin
                    fin        = 1'b1;
                    fin_status = urs_pkg::ST_NOT_READY;
                end
            endcase

            if (fin)
            begin
                phase_next         = urs_pkg::PH_IDLE;
                measuring_next     = 1'b0;
                active_next        = '0;
                next_idx_next      = (active_reg == LAST_IDX) ? '0 : active_reg + 1'b1;
                next_start_next    = now_us + {12'd0, gap_reg};
                a_res_next.done    = 1'b1;
                a_res_next.channel = 2'(active_reg);
                a_res_next.status  = fin_status;
                a_res_next.width   = (fin_status == urs_pkg::ST_OK) ? dur[19:0] : 20'd0;
                a_res_next.time_ms = in_ch.time_ms;
            end
        end

        if (measuring_next && phase_next == urs_pkg::PH_TRIG_HIGH)
        begin
            a_res_next.trigger_lines = 3'(8'd1 << ch_ext);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            measuring_reg   <= 1'b0;
            active_reg      <= '0;
            next_idx_reg    <= '0;
            next_start_reg  <= 32'd0;
            phase_reg       <= urs_pkg::PH_IDLE;
            phase_start_reg <= 32'd0;
        end
        else if (accept)
        begin
            measuring_reg   <= measuring_next;
            active_reg      <= active_next;
            next_idx_reg    <= next_idx_next;
            next_start_reg  <= next_start_next;
            phase_reg       <= phase_next;
            phase_start_reg <= phase_start_next;
        end
    end

    // width scaling: (w * 343 + 1000) >> 4
    assign width_x  = 29'(a_res_reg.width);
    assign scaled_x = (width_x << 8) + (width_x << 6) + (width_x << 4)
                    + (width_x << 2) + (width_x << 1) + width_x + urs_pkg::MM_ROUND;

    // divide by 125 through the reciprocal, then saturate; zero unless a good measurement finished
    assign product  = 51'(b_scaled_reg) * 51'(urs_pkg::RECIP_125);
    assign quotient = product[50:32];
    assign sat_mm   = (b_res_reg.status != urs_pkg::ST_OK || !b_res_reg.done) ? 16'd0
                    : (quotient > 19'(urs_pkg::MM_MAX)) ? urs_pkg::MM_MAX
                    : quotient[15:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= in_ch.valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_ready)
            begin
                out_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_res_reg <= a_res_next;
        end
        if (b_ready && a_valid_reg)
        begin
            b_res_reg    <= a_res_reg;
            b_scaled_reg <= scaled_x[28:4];
        end
        if (c_ready && b_valid_reg)
        begin
            out_res_reg  <= b_res_reg;
            out_dist_reg <= sat_mm;
        end
    end

    assign out_ch.valid            = out_valid_reg;
    assign out_ch.trigger_lines    = out_res_reg.trigger_lines;
    assign out_ch.measurement_done = out_res_reg.done;
    assign out_ch.done_channel     = out_res_reg.channel;
    assign out_ch.done_status      = out_res_reg.status;
    assign out_ch.range_mm         = out_dist_reg;
    assign out_ch.echo_width_us    = out_res_reg.width;
    assign out_ch.update_time_ms   = out_res_reg.time_ms;

`ifndef SYNTH
    a_idle_when_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        !measuring_reg |-> phase_reg == urs_pkg::PH_IDLE)
        else $error("phase not idle while no channel is measured");

    a_single_trigger: assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg |-> $onehot0(a_res_reg.trigger_lines))
        else $error("more than one trigger line high");

    a_failed_width_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && a_res_reg.status != urs_pkg::ST_OK) |-> a_res_reg.width == 20'd0)
        else $error("width kept on a failed measurement");

    a_distance_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_dist_reg != 16'd0)
            |-> (out_res_reg.done && out_res_reg.status == urs_pkg::ST_OK))
        else $error("distance reported without a good measurement");

    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (b_valid_reg && !c_ready) |=> b_valid_reg)
        else $error("middle stage dropped a result under stall");
`endif

endmodule

// ===== test/ultrasonic_ranging_sequencer_unit_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench of the ultrasonic ranging sequencer with a tick-level scoreboard
module ultrasonic_ranging_sequencer_unit_tb;

    localparam int NUM_CH      = urs_pkg::NUM_CHANNELS;
    localparam int HOLD_CYCLES = 150;

    typedef struct packed {
        logic [2:0]  trigger_lines;
        logic        done;
        logic [1:0]  channel;
        logic [2:0]  status;
        logic [15:0] distance;
        logic [19:0] width;
        logic [31:0] stamp;
    } tick_result_t;

    typedef enum logic [1:0] {
        ECHO_NORMAL,
        ECHO_SILENT,
        ECHO_STUCK,
        ECHO_OVERLONG
    } echo_plan_t;

    class ranging_tracker;
        int unsigned      mismatches;
        tick_result_t     expected_ticks[$];
        logic [19:0]      echo_timeout;
        logic [15:0]      settle_time;
        logic [15:0]      pulse_time;
        logic [19:0]      channel_gap;
        bit               measuring;
        int unsigned      active_ch;
        int unsigned      next_ch;
        logic [31:0]      next_start;
        urs_pkg::phase_t  phase [NUM_CH];
        logic [31:0]      phase_start [NUM_CH];
        logic [31:0]      rise_time [NUM_CH];

        function new();
            mismatches   = 0;
            echo_timeout = urs_pkg::ECHO_TIMEOUT_RST;
            settle_time  = urs_pkg::SETTLE_RST;
            pulse_time   = urs_pkg::PULSE_RST;
            channel_gap  = urs_pkg::GAP_RST;
            measuring    = 1'b0;
            active_ch    = 0;
            next_ch      = 0;
            next_start   = '0;
            for (int i = 0; i < NUM_CH; i++)
            begin
                phase[i]       = urs_pkg::PH_IDLE;
                phase_start[i] = '0;
                rise_time[i]   = '0;
            end
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                urs_pkg::REG_ECHO_TIMEOUT: echo_timeout = value[19:0];
                urs_pkg::REG_SETTLE:       settle_time  = value[15:0];
                urs_pkg::REG_PULSE:        pulse_time   = value[15:0];
                urs_pkg::REG_GAP:          channel_gap  = value[19:0];
                default:                   ;
            endcase
        endfunction

        function logic [31:0] reg_value(logic [1:0] idx);
            case (idx)
                urs_pkg::REG_ECHO_TIMEOUT: reg_value = {12'd0, echo_timeout};
                urs_pkg::REG_SETTLE:       reg_value = {16'd0, settle_time};
                urs_pkg::REG_PULSE:        reg_value = {16'd0, pulse_time};
                default:                   reg_value = {12'd0, channel_gap};
            endcase
        endfunction

        function void complete(inout tick_result_t r, input int unsigned ch,
                               input logic [2:0] status, input logic [31:0] w,
                               input logic [31:0] now_us, input logic [31:0] now_ms);
            longint unsigned mm;
            phase[ch]  = urs_pkg::PH_IDLE;
            next_ch    = (ch + 1) % NUM_CH;
            measuring  = 1'b0;
            active_ch  = 0;
            next_start = now_us + {12'd0, channel_gap};
            r.done     = 1'b1;
            r.channel  = ch[1:0];
            r.status   = status;
            r.stamp    = now_ms;
            if (status == urs_pkg::ST_OK)
            begin
                mm         = (longint'(w) * 343 + 1000) / 2000;
                r.width    = w[19:0];
                r.distance = (mm > 65535) ? urs_pkg::MM_MAX : mm[15:0];
            end
        endfunction

        function void note_tick(logic [31:0] now_us, logic [31:0] now_ms, logic [2:0] levels);
            tick_result_t r;
            logic [31:0]  dur;
            logic [31:0]  w;
            logic [31:0]  diff;
            int unsigned  ch;
            bit           echo;
            r = '0;
            if (!measuring)
            begin
                diff = now_us - next_start;
                if (!diff[31])
                begin
                    ch              = next_ch % NUM_CH;
                    measuring       = 1'b1;
                    active_ch       = ch;
                    phase_start[ch] = now_us;
                    phase[ch]       = levels[ch] ? urs_pkg::PH_WAIT_LOW : urs_pkg::PH_SETTLE;
                end
                expected_ticks.push_back(r);
                return;
            end
            ch   = active_ch % NUM_CH;
            dur  = now_us - phase_start[ch];
            echo = levels[ch];
            case (phase[ch])
                urs_pkg::PH_WAIT_LOW:
                begin
                    if (!echo)
                    begin
                        phase[ch]       = urs_pkg::PH_SETTLE;
                        phase_start[ch] = now_us;
                    end
                    else if (dur >= echo_timeout)
                        complete(r, ch, urs_pkg::ST_ECHO_NOT_LOW, '0, now_us, now_ms);
                end
                urs_pkg::PH_SETTLE:
                begin
                    if (dur >= settle_time)
                    begin
                        phase[ch]       = urs_pkg::PH_TRIG_HIGH;
                        phase_start[ch] = now_us;
                    end
                end
                urs_pkg::PH_TRIG_HIGH:
                begin
                    if (dur >= pulse_time)
                    begin
                        phase[ch]       = urs_pkg::PH_WAIT_RISE;
                        phase_start[ch] = now_us;
                    end
                end
                urs_pkg::PH_WAIT_RISE:
                begin
                    if (echo)
                    begin
                        rise_time[ch]   = now_us;
                        phase[ch]       = urs_pkg::PH_WAIT_FALL;
                        phase_start[ch] = now_us;
                    end
                    else if (dur >= echo_timeout)
                        complete(r, ch, urs_pkg::ST_RISE_TIMEOUT, '0, now_us, now_ms);
                end
                urs_pkg::PH_WAIT_FALL:
                begin
                    if (!echo)
                    begin
                        w = now_us - rise_time[ch];
                        if (w == 0 || w >= echo_timeout)
                            complete(r, ch, urs_pkg::ST_OUT_OF_BOUNDS, '0, now_us, now_ms);
                        else
                            complete(r, ch, urs_pkg::ST_OK, w, now_us, now_ms);
                    end
                    else if (dur >= echo_timeout)
                        complete(r, ch, urs_pkg::ST_FALL_TIMEOUT, '0, now_us, now_ms);
                end
                default:
                    complete(r, ch, urs_pkg::ST_NOT_READY, '0, now_us, now_ms);
            endcase
            if (measuring && phase[ch] == urs_pkg::PH_TRIG_HIGH)
                r.trigger_lines[ch] = 1'b1;
            expected_ticks.push_back(r);
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            $display("[%0t] mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
            mismatches++;
        endtask

        task check_result(tick_result_t got);
            tick_result_t want;
            if (expected_ticks.size() == 0)
            begin
                report_mismatch("result transfer with no tick pending", got.stamp, '0);
                return;
            end
            want = expected_ticks.pop_front();
            if (got.trigger_lines !== want.trigger_lines)
                report_mismatch("trigger_lines", 32'(got.trigger_lines),
                                32'(want.trigger_lines));
            if (got.done !== want.done)
                report_mismatch("measurement_done", 32'(got.done), 32'(want.done));
            if (got.channel !== want.channel)
                report_mismatch("done_channel", 32'(got.channel), 32'(want.channel));
            if (got.status !== want.status)
                report_mismatch("done_status", 32'(got.status), 32'(want.status));
            if (got.distance !== want.distance)
                report_mismatch("range_mm", 32'(got.distance), 32'(want.distance));
            if (got.width !== want.width)
                report_mismatch("echo_width_us", 32'(got.width), 32'(want.width));
            if (got.stamp !== want.stamp)
                report_mismatch("update_time_ms", got.stamp, want.stamp);
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    urs_in_if  tick_if ();
    urs_out_if result_if ();

    ultrasonic_ranging_sequencer_unit DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (tick_if),
        .out_ch  (result_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    ranging_tracker tracker = new();

    bit          steady;
    bit          hold_request;
    logic [31:0] now_us;
    echo_plan_t  plan;
    bit          armed;
    logic [31:0] rise_at;
    logic [31:0] fall_at;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // result side: random stalls plus one long hold-off
    initial
    begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        result_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                result_if.ready <= 1'b0;
                hold_left--;
            end
            else if (hold_request && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                result_if.ready <= 1'b0;
            end
            else
                result_if.ready <= steady || ($urandom_range(99) >= 22);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_if.valid && result_if.ready)
            tracker.check_result(tick_result_t'{result_if.trigger_lines,
                                                result_if.measurement_done,
                                                result_if.done_channel,
                                                result_if.done_status,
                                                result_if.range_mm,
                                                result_if.echo_width_us,
                                                result_if.update_time_ms});
    end

    initial
    begin
        #2_000_000;
        $display("ultrasonic_ranging_sequencer_unit verification failed");
        $finish;
    end

    task automatic send_tick(input logic [31:0] us, input logic [31:0] ms,
                             input logic [2:0] levels);
        while (!steady && $urandom_range(99) < 22)
        begin
            tick_if.valid <= 1'b0;
            @(posedge clk);
        end
        tick_if.valid       <= 1'b1;
        tick_if.time_us     <= us;
        tick_if.time_ms     <= ms;
        tick_if.echo_levels <= levels;
        do
        begin
            @(posedge clk);
        end
        while (!tick_if.ready);
        tracker.note_tick(us, ms, levels);
    endtask

    task automatic wait_drained();
        while (tracker.expected_ticks.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic program_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        tracker.write_reg(idx, value);
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        if (prdata !== tracker.reg_value(idx))
            tracker.report_mismatch("register readback", prdata, tracker.reg_value(idx));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_setting(input logic [31:0] timeout, input logic [31:0] settle,
                                 input logic [31:0] pulse, input logic [31:0] gap);
        program_reg(urs_pkg::REG_ECHO_TIMEOUT, timeout);
        program_reg(urs_pkg::REG_SETTLE, settle);
        program_reg(urs_pkg::REG_PULSE, pulse);
        program_reg(urs_pkg::REG_GAP, gap);
    endtask

    // sensor model: echoes follow the trigger with a planned delay and width
    task automatic run_random(input int count);
        int unsigned to;
        int unsigned step;
        int unsigned ch;
        logic [2:0]  levels;
        logic [31:0] since_rise;
        logic [31:0] since_fall;
        repeat (count)
        begin
            to     = tracker.echo_timeout;
            levels = $urandom_range(7, 0);
            if (!tracker.measuring)
            begin
                ch    = tracker.next_ch;
                armed = 1'b0;
                case ($urandom_range(9, 0))
                    0:       plan = ECHO_SILENT;
                    1:       plan = ECHO_STUCK;
                    2:       plan = ECHO_OVERLONG;
                    default: plan = ECHO_NORMAL;
                endcase
                step = $urandom_range(tracker.channel_gap / 3 + 2, 0);
                levels[ch] = (plan == ECHO_STUCK) || ($urandom_range(3, 0) == 0);
            end
            else
            begin
                ch = tracker.active_ch;
                case (tracker.phase[ch])
                    urs_pkg::PH_WAIT_LOW:
                    begin
                        step = $urandom_range(to / 4 + 1, 0);
                        levels[ch] = (plan == ECHO_STUCK) || ($urandom_range(1, 0) == 1);
                    end
                    urs_pkg::PH_SETTLE:
                        step = $urandom_range(tracker.settle_time + 1, 0);
                    urs_pkg::PH_TRIG_HIGH:
                        step = $urandom_range(tracker.pulse_time / 2 + 2, 0);
                    default:
                        step = $urandom_range(to / 6 + 1, 0);
                endcase
            end
            if ($urandom_range(99, 0) < 10)
                step = 0;
            else if ($urandom_range(99, 0) < 3)
                step = $urandom_range(32'h7000_0000, 0);
            now_us += step;
            if (tracker.measuring && (tracker.phase[ch] == urs_pkg::PH_WAIT_RISE ||
                                      tracker.phase[ch] == urs_pkg::PH_WAIT_FALL))
            begin
                if (!armed)
                begin
                    armed   = 1'b1;
                    rise_at = tracker.phase_start[ch] + ((to > 1) ? $urandom_range(to - 1, 0) : 0);
                    if (plan == ECHO_OVERLONG)
                        fall_at = rise_at + to + $urandom_range(to / 8, 0);
                    else
                        fall_at = rise_at + ((to > 1) ? $urandom_range(to - 1, 1) : 1);
                end
                since_rise = now_us - rise_at;
                since_fall = now_us - fall_at;
                levels[ch] = (plan != ECHO_SILENT) && !since_rise[31] && since_fall[31];
            end
            send_tick(now_us, $urandom, levels);
        end
        tick_if.valid <= 1'b0;
    endtask

    initial
    begin
        rst_n               <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        tick_if.valid       <= 1'b0;
        tick_if.time_us     <= '0;
        tick_if.time_ms     <= '0;
        tick_if.echo_levels <= '0;
        steady       = 1'b0;
        hold_request = 1'b0;
        plan         = ECHO_NORMAL;
        armed        = 1'b0;
        rise_at      = '0;
        fall_at      = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed walk through the echo-not-low, out-of-bounds, rise-timeout and ok completions at the default timing
        send_tick(32'hffff_ffff, 32'hffff_ffff, 3'b111);
        send_tick(32'h8000_0000, 32'd0, 3'b000);
        send_tick(32'd0, 32'd1, 3'b001);
        send_tick(32'd29999, 32'd2, 3'b001);
        send_tick(32'd30000, 32'hffff_ffff, 3'b111);
        send_tick(32'd89999, 32'd3, 3'b000);
        send_tick(32'd90000, 32'd4, 3'b101);
        send_tick(32'd90001, 32'd5, 3'b010);
        send_tick(32'd90002, 32'd6, 3'b000);
        send_tick(32'd90011, 32'd7, 3'b000);
        send_tick(32'd90012, 32'd8, 3'b000);
        send_tick(32'd90012, 32'd9, 3'b010);
        send_tick(32'd90012, 32'd10, 3'b000);
        send_tick(32'd150012, 32'd11, 3'b000);
        send_tick(32'd150014, 32'd12, 3'b000);
        send_tick(32'd150024, 32'd13, 3'b000);
        send_tick(32'd180023, 32'd14, 3'b011);
        send_tick(32'd180024, 32'd15, 3'b000);
        send_tick(32'd240024, 32'd16, 3'b000);
        send_tick(32'd240026, 32'd17, 3'b000);
        send_tick(32'd240036, 32'd18, 3'b000);
        send_tick(32'd240100, 32'd19, 3'b001);
        send_tick(32'd245931, 32'd20, 3'b000);
        send_tick(32'd305931, 32'd21, 3'b010);
        send_tick(32'd305931, 32'd22, 3'b000);
        now_us = 32'd305931;
        run_random(130);
        wait_drained();

        apply_setting(32'd0, 32'd0, 32'd0, 32'd0);
        run_random(70);
        wait_drained();

        apply_setting(32'd1000000, 32'd65535, 32'd65535, 32'd1000000);
        run_random(120);
        wait_drained();

        apply_setting($urandom_range(40000, 200), $urandom_range(20, 0),
                      $urandom_range(50, 0), $urandom_range(5000, 0));
        steady       = 1'b1;
        hold_request = 1'b1;
        run_random(110);
        steady = 1'b0;
        wait_drained();
        run_random(70);
        wait_drained();

        apply_setting(32'd1, 32'd0, 32'd1, 32'd1);
        run_random(80);
        wait_drained();

        apply_setting($urandom, $urandom, $urandom, $urandom);
        run_random(150);
        wait_drained();

        repeat (20) @(posedge clk);
        if (tracker.mismatches == 0)
            $display("ultrasonic_ranging_sequencer_unit verification clean");
        else
            $display("ultrasonic_ranging_sequencer_unit verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
design/urs_pkg.sv
design/urs_if.sv
design/ultrasonic_ranging_sequencer_unit.sv
test/ultrasonic_ranging_sequencer_unit_tb.sv
